// ===== sv/qts_pkg.sv =====
// Shared types, constants and helpers for the quoted token splitter.
package qts_pkg;

  localparam int COUNT_BITS = 16;
  // token counter saturates at 2^CNT_W-1, never above 65535
  localparam int CNT_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;
  localparam logic [CNT_W-1:0] CNT_LIMIT = '1;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [15:0] POS_LIMIT = 16'hFFFF;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2
  } quote_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  token_byte;
    logic [15:0] token_count;
    logic        last_result;
  } result_t;

  // up to three results from one byte, in emission order
  typedef struct packed {
    logic    take_v;
    result_t take;
    logic    close_v;
    result_t close;
    logic    done_v;
    result_t done;
  } push_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_LIMIT) ? v : v + 1'b1;
  endfunction

endpackage

// ===== sv/qts_in_if.sv =====
// Input byte channel: valid/ready with one string byte per beat.
interface qts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== sv/qts_out_if.sv =====
// Result channel: valid/ready with one tokenizer result per beat.
interface qts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  token_byte;
  logic [15:0] token_count;
  logic        last_result;

  modport source (output valid, output kind, output token_byte, output token_count,
                  output last_result, input ready);
  modport sink   (input valid, input kind, input token_byte, input token_count,
                  input last_result, output ready);
endinterface

// ===== sv/qts_core.sv =====
// Input register, tokenizer state and per-byte result generation.
module qts_core
  import qts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  qts_in_if.sink      bytes,
  input  logic        room,
  output push_t       push
);

  logic        in_v;
  logic [7:0]  in_b;
  logic        in_l;
  logic        go;

  logic [15:0]      start_offset;
  logic             inside_token;
  logic             escape_pending;
  quote_t           open_quote;
  logic             token_has_bytes;
  logic [CNT_W-1:0] tokens_done;
  logic [15:0]      byte_position;

  logic             t_inside;
  logic             t_esc;
  quote_t           t_oq;
  logic             t_has;
  logic [CNT_W-1:0] t_tok;
  logic [CNT_W-1:0] c_tok;
  logic             quoted;
  logic [7:0]       qch;
  push_t            res;

  assign go          = in_v && room;
  assign bytes.ready = !in_v || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (bytes.ready) begin
      in_v <= bytes.valid;
    end
    if (bytes.valid && bytes.ready) begin
      in_b <= bytes.data_byte;
      in_l <= bytes.last_byte;
    end
  end

  always_comb begin
    quoted = (open_quote == QUOTE_DOUBLE) || (open_quote == QUOTE_SINGLE);
    qch    = (open_quote == QUOTE_DOUBLE) ? CH_DQ :
             (open_quote == QUOTE_SINGLE) ? CH_SQ : CH_NUL;

    t_inside = inside_token;
    t_esc    = escape_pending;
    t_oq     = open_quote;
    t_has    = token_has_bytes;
    t_tok    = tokens_done;
    res      = '0;

    if (byte_position >= start_offset) begin
      t_inside = inside_token || !is_space(in_b);
      if (t_inside) begin
        // unquoted NUL matches the empty quote char and closes the token
        if (escape_pending || (in_b != qch && in_b != CH_BSL &&
            (quoted || (in_b != CH_DQ && in_b != CH_SQ && !is_space(in_b))))) begin
          t_esc                 = 1'b0;
          t_has                 = 1'b1;
          res.take_v            = 1'b1;
          res.take.kind         = KIND_BYTE;
          res.take.token_byte   = in_b;
          res.take.token_count  = 16'(tokens_done);
        end else if (in_b == qch || (!quoted && is_space(in_b))) begin
          t_tok                 = sat_inc(tokens_done);
          t_inside              = 1'b0;
          t_oq                  = QUOTE_NONE;
          t_has                 = 1'b0;
          res.take_v            = 1'b1;
          res.take.kind         = KIND_END;
          res.take.token_count  = 16'(t_tok);
        end else if (in_b == CH_BSL) begin
          t_esc = 1'b1;
        end else if (in_b == CH_DQ) begin
          t_oq = QUOTE_DOUBLE;
        end else begin
          t_oq = QUOTE_SINGLE;
        end
      end
    end

    // flush a token with bytes at end of string; drop an empty one
    c_tok = t_tok;
    if (in_l && t_inside && t_has) begin
      c_tok                 = sat_inc(t_tok);
      res.close_v           = 1'b1;
      res.close.kind        = KIND_END;
      res.close.token_count = 16'(c_tok);
    end
    res.done_v           = in_l;
    res.done.kind        = KIND_DONE;
    res.done.token_count = 16'(c_tok);
    res.done.last_result = 1'b1;

    push         = res;
    push.take_v  = res.take_v && go;
    push.close_v = res.close_v && go;
    push.done_v  = res.done_v && go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset    <= '0;
      inside_token    <= 1'b0;
      escape_pending  <= 1'b0;
      open_quote      <= QUOTE_NONE;
      token_has_bytes <= 1'b0;
      tokens_done     <= '0;
      byte_position   <= '0;
    end else begin
      if (cfg_we) begin
        start_offset <= cfg_wdata;
      end
      if (go) begin
        if (in_l) begin
          inside_token    <= 1'b0;
          escape_pending  <= 1'b0;
          open_quote      <= QUOTE_NONE;
          token_has_bytes <= 1'b0;
          tokens_done     <= '0;
          byte_position   <= '0;
        end else begin
          inside_token    <= t_inside;
          escape_pending  <= t_esc;
          open_quote      <= t_oq;
          token_has_bytes <= t_has;
          tokens_done     <= t_tok;
          if (byte_position != POS_LIMIT) begin
            byte_position <= byte_position + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== sv/qts_result_fifo.sv =====
// Result queue: takes up to three results per cycle, drains one beat per cycle while the sink is ready.
module qts_result_fifo
  import qts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  push_t       push,
  output logic        room,
  qts_out_if.source   tokens
);

  result_t           mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [FCNT_W-1:0] count;
  logic [PTR_W-1:0]  w1;
  logic [PTR_W-1:0]  w2;
  logic [FCNT_W-1:0] nwr;
  logic              pop;
  result_t           hd;

  assign room = (count <= FCNT_W'(FIFO_DEPTH - 3));
  assign pop  = tokens.valid && tokens.ready;

  always_comb begin
    w1  = tail + PTR_W'(push.take_v);
    w2  = w1 + PTR_W'(push.close_v);
    nwr = FCNT_W'(push.take_v) + FCNT_W'(push.close_v) + FCNT_W'(push.done_v);
  end

  always_ff @(posedge clk) begin
    if (push.take_v) begin
      mem[tail] <= push.take;
    end
    if (push.close_v) begin
      mem[w1] <= push.close;
    end
    if (push.done_v) begin
      mem[w2] <= push.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + nwr[PTR_W-1:0];
      head  <= head + PTR_W'(pop);
      count <= count + nwr - FCNT_W'(pop);
    end
  end

  assign hd                 = mem[head];
  assign tokens.valid       = (count != '0);
  assign tokens.kind        = hd.kind;
  assign tokens.token_byte  = hd.token_byte;
  assign tokens.token_count = hd.token_count;
  assign tokens.last_result = hd.last_result;

endmodule

// ===== sv/quoted_token_splitter.sv =====
// Path: an accepted byte is held in the input register; its results are written
// into the result queue when the queue has room, and the first is offered from its head.
// Throughput: one byte per cycle while the result queue has room; a byte yields up
// to three results, which leave through the four-entry result queue one beat per
// cycle, so bursts of multi-result bytes are paced by that single output port.
// Reset: synchronous, active high; clears the queue, tokenizer state and
// start_offset.
module quoted_token_splitter
  import qts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  qts_in_if.sink      bytes,
  qts_out_if.source   tokens
);

  push_t push;
  logic  room;

  qts_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .bytes     (bytes),
    .room      (room),
    .push      (push)
  );

  qts_result_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .tokens (tokens)
  );

endmodule

// ===== sv/qts_checker.sv =====
// Port-level assertions for the quoted token splitter, bound to the top level.
module qts_checker
  import qts_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_token_byte,
  input logic        out_last_result
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // last_result marks exactly the end-of-string beat
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last_result == (out_kind == KIND_DONE)))
    else $error("last_result and kind disagree");

  // only token-byte beats carry a byte
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != KIND_BYTE) |-> (out_token_byte == 8'h00))
    else $error("nonzero token_byte on a mark beat");

  // hold a stalled beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_kind)))
    else $error("stalled result dropped or changed");

endmodule

bind quoted_token_splitter qts_checker u_qts_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (tokens.valid),
  .out_ready       (tokens.ready),
  .out_kind        (tokens.kind),
  .out_token_byte  (tokens.token_byte),
  .out_last_result (tokens.last_result)
);

// ===== tb/tb.sv =====
// Testbench for quoted_token_splitter: directed table and random strings.
`timescale 1ns / 100ps

module tb
  import qts_pkg::*;
();

  localparam int RANDOM_ITEMS = 285;
  localparam int SETTLE       = 4;
  localparam int WATCHDOG     = 1000;

  typedef enum logic {ROW_BYTE, ROW_OFFSET} row_op_t;

  typedef struct packed {
    row_op_t     op;
    logic [7:0]  b;
    logic        fin;
    logic [15:0] value;
    logic        known;
    logic [1:0]  n;
    result_t     r0;
    result_t     r1;
    result_t     r2;
  } plan_row_t;

  localparam result_t NO_RES = '0;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  qts_in_if  in_ch ();
  qts_out_if out_ch ();

  quoted_token_splitter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .bytes     (in_ch),
    .tokens    (out_ch)
  );

  // tokenizer shadow state
  logic [15:0] offset_r;
  logic        tok_open;
  logic        esc_next;
  quote_t      quote_st;
  logic        tok_nonempty;
  logic [15:0] tok_total;
  logic [15:0] byte_pos;

  result_t     step_results[$];
  result_t     pending_results[$];
  plan_row_t   plan[$];
  logic [7:0]  str_q[$];

  bit calm;
  int mismatches;
  int beats_checked;
  int bytes_sent;
  int strings_sent;
  int offset_writes;
  int random_bytes;
  int quiet;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic blank(input logic [7:0] b);
    return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic result_t res(input kind_t k, input logic [7:0] b,
                                  input logic [15:0] c, input logic l);
    result_t r;
    r.kind        = k;
    r.token_byte  = b;
    r.token_count = c;
    r.last_result = l;
    return r;
  endfunction

  task automatic emit_result(input kind_t k, input logic [7:0] b, input logic l);
    step_results = {step_results, res(k, b, tok_total, l)};
  endtask

  task automatic close_token();
    if (tok_total != 16'(CNT_LIMIT)) tok_total = tok_total + 16'd1;
    tok_open     = 1'b0;
    quote_st     = QUOTE_NONE;
    tok_nonempty = 1'b0;
    emit_result(KIND_END, 8'h00, 1'b0);
  endtask

  task automatic add_char(input logic [7:0] b);
    tok_nonempty = 1'b1;
    emit_result(KIND_BYTE, b, 1'b0);
  endtask

  task automatic clear_string();
    tok_open     = 1'b0;
    esc_next     = 1'b0;
    quote_st     = QUOTE_NONE;
    tok_nonempty = 1'b0;
    tok_total    = '0;
    byte_pos     = '0;
  endtask

  // Work out the results of one accepted byte into step_results.
  task automatic split_byte(input logic [7:0] b, input logic fin);
    logic       quoted;
    logic [7:0] qch;
    step_results.delete();
    if (byte_pos >= offset_r) begin
      quoted = (quote_st == QUOTE_DOUBLE) || (quote_st == QUOTE_SINGLE);
      if (!tok_open && !blank(b)) tok_open = 1'b1;
      if (tok_open) begin
        // outside quotes the match byte is NUL, so a bare NUL ends the token
        qch = (quote_st == QUOTE_DOUBLE) ? CH_DQ :
              (quote_st == QUOTE_SINGLE) ? CH_SQ : CH_NUL;
        if (esc_next) begin
          add_char(b);
          esc_next = 1'b0;
        end else if (b == qch) begin
          close_token();
        end else if (b == CH_BSL) begin
          esc_next = 1'b1;
        end else if (quoted) begin
          add_char(b);
        end else if (b == CH_DQ) begin
          quote_st = QUOTE_DOUBLE;
        end else if (b == CH_SQ) begin
          quote_st = QUOTE_SINGLE;
        end else if (blank(b)) begin
          close_token();
        end else begin
          add_char(b);
        end
      end
    end
    if (byte_pos != 16'hFFFF) byte_pos = byte_pos + 16'd1;
    if (fin) begin
      if (tok_open && tok_nonempty) close_token();
      emit_result(KIND_DONE, 8'h00, 1'b1);
      clear_string();
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] beat %0d %s: got %0d want %0d", $time, beats_checked, what, got, want);
  endtask

  // Hold valid high across back-to-back beats; drop it only for a gap.
  task automatic push_byte(input logic [7:0] b, input logic fin, input logic keep);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    split_byte(b, fin);
    if (keep) pending_results = {pending_results, step_results};
    bytes_sent++;
    if (fin) strings_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // let a byte with no results drain out of the pipeline
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_offset(input logic [15:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    offset_r  = v;
    offset_writes++;
  endtask

  function automatic logic [15:0] pick_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'd0;
    if (r < 85) return 16'($urandom_range(1, 6));
    if (r < 90) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] noise_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return CH_DQ;
    if (r < 22) return CH_SQ;
    if (r < 30) return CH_BSL;
    if (r < 36) return CH_NUL;
    if (r < 50) return 8'($urandom_range(9, 13));
    if (r < 56) return CH_SP;
    return 8'($urandom_range(0, 255));
  endfunction

  // Plain words avoid blanks, quotes, backslash and NUL; quoted text avoids its quote.
  function automatic logic [7:0] word_char(input int style);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_BSL || (style == 1 && c == CH_DQ) || (style == 2 && c == CH_SQ) ||
           (style == 0 && (blank(c) || c == CH_NUL || c == CH_DQ || c == CH_SQ)))
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic void build_string();
    int ntok;
    int style;
    int len;
    str_q.delete();
    if ($urandom_range(0, 3) == 0) begin
      len = $urandom_range(1, 12);
      repeat (len) str_q = {str_q, noise_byte()};
    end else begin
      ntok = $urandom_range(1, 4);
      repeat (ntok) begin
        repeat ($urandom_range(0, 2)) str_q = {str_q, 8'($urandom_range(0, 1) ? 32 : 9)};
        style = $urandom_range(0, 2);
        if (style == 1) str_q = {str_q, CH_DQ};
        if (style == 2) str_q = {str_q, CH_SQ};
        len = $urandom_range(0, 5);
        repeat (len) begin
          if ($urandom_range(0, 7) == 0) begin
            str_q = {str_q, CH_BSL};
            str_q = {str_q, noise_byte()};
          end else begin
            str_q = {str_q, word_char(style)};
          end
        end
        // leave a quote open now and then
        if (style != 0 && $urandom_range(0, 7) != 0)
          str_q = {str_q, (style == 1) ? CH_DQ : CH_SQ};
      end
    end
    if (str_q.size() == 0) str_q = {str_q, 8'h61};
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic fin);
    plan_row_t r;
    r     = '0;
    r.op  = ROW_BYTE;
    r.b   = b;
    r.fin = fin;
    plan = {plan, r};
  endtask

  task automatic add_known(input logic [7:0] b, input logic fin, input logic [1:0] n,
                           input result_t r0, input result_t r1, input result_t r2);
    plan_row_t r;
    r       = '0;
    r.op    = ROW_BYTE;
    r.b     = b;
    r.fin   = fin;
    r.known = 1'b1;
    r.n     = n;
    r.r0    = r0;
    r.r1    = r1;
    r.r2    = r2;
    plan = {plan, r};
  endtask

  task automatic add_offset(input logic [15:0] v);
    plan_row_t r;
    r       = '0;
    r.op    = ROW_OFFSET;
    r.value = v;
    plan = {plan, r};
  endtask

  // Result side: check each beat, then pick the next ready level.
  always @(posedge clk) begin
    result_t w;
    int      g;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          note_mismatch("result with nothing pending, kind", int'(out_ch.kind), -1);
        end else begin
          w = pending_results.pop_front();
          if (out_ch.kind != w.kind)
            note_mismatch("kind", int'(out_ch.kind), int'(w.kind));
          if (out_ch.token_byte != w.token_byte)
            note_mismatch("token_byte", int'(out_ch.token_byte), int'(w.token_byte));
          if (out_ch.token_count != w.token_count)
            note_mismatch("token_count", int'(out_ch.token_count), int'(w.token_count));
          if (out_ch.last_result != w.last_result)
            note_mismatch("last_result", int'(out_ch.last_result), int'(w.last_result));
        end
        beats_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        g = calm ? 0 : pick_gap();
        if (g == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left = g - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending",
               WATCHDOG, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    int k;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    calm            = 1'b0;
    offset_r        = '0;
    clear_string();

    // whole one-byte token: byte, end, done
    add_known("a", 1'b1, 2'd3, res(KIND_BYTE, "a", 16'd0, 1'b0),
              res(KIND_END, 8'h00, 16'd1, 1'b0), res(KIND_DONE, 8'h00, 16'd1, 1'b1));
    // empty quoted token, then a lone backslash at the end is dropped
    add_known(CH_DQ, 1'b0, 2'd0, NO_RES, NO_RES, NO_RES);
    add_known(CH_DQ, 1'b0, 2'd1, res(KIND_END, 8'h00, 16'd1, 1'b0), NO_RES, NO_RES);
    add_known(CH_SP, 1'b0, 2'd0, NO_RES, NO_RES, NO_RES);
    add_known(CH_BSL, 1'b1, 2'd1, res(KIND_DONE, 8'h00, 16'd1, 1'b1), NO_RES, NO_RES);
    // single quotes, escapes inside quotes, bare NUL, high bytes, whitespace edges
    add_byte(CH_SQ, 1'b0);
    add_byte("q", 1'b0);
    add_byte(CH_DQ, 1'b0);
    add_byte(CH_BSL, 1'b0);
    add_byte(CH_SQ, 1'b0);
    add_byte(CH_SQ, 1'b0);
    add_byte(CH_NUL, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(CH_TAB, 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h0E, 1'b0);
    add_byte(8'h08, 1'b0);
    add_byte(CH_SP, 1'b0);
    // unclosed quote with bytes is flushed at the end
    add_byte(CH_DQ, 1'b0);
    add_byte("z", 1'b1);
    // offset change mid-string, then a skipped final byte
    add_byte("k", 1'b0);
    add_offset(16'd5);
    add_byte("m", 1'b1);
    add_known("x", 1'b1, 2'd1, res(KIND_DONE, 8'h00, 16'd0, 1'b1), NO_RES, NO_RES);
    add_offset(16'hFFFF);
    add_known("A", 1'b1, 2'd1, res(KIND_DONE, 8'h00, 16'd0, 1'b1), NO_RES, NO_RES);
    add_offset(16'd0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (p = 0; p < plan.size(); p++) begin
      if (plan[p].op == ROW_OFFSET) begin
        write_offset(plan[p].value);
      end else begin
        push_byte(plan[p].b, plan[p].fin, !plan[p].known);
        if (plan[p].known) begin
          if (plan[p].n > 0) pending_results = {pending_results, plan[p].r0};
          if (plan[p].n > 1) pending_results = {pending_results, plan[p].r1};
          if (plan[p].n > 2) pending_results = {pending_results, plan[p].r2};
        end
      end
    end

    random_bytes = 0;
    while (random_bytes < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) write_offset(pick_offset());
      calm = ($urandom_range(0, 5) == 0);
      build_string();
      for (k = 0; k < str_q.size(); k++) push_byte(str_q[k], k == str_q.size() - 1, 1'b1);
      random_bytes += str_q.size();
      if ($urandom_range(0, 11) == 0) wait_idle();
    end
    calm = 1'b0;

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);

    $display("Drove %0d bytes in %0d strings with %0d offset writes, gaps on both sides",
             bytes_sent, strings_sent, offset_writes);
    $display("Compared %0d result beats, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== quoted_token_splitter.f =====
sv/qts_pkg.sv
sv/qts_in_if.sv
sv/qts_out_if.sv
sv/qts_core.sv
sv/qts_result_fifo.sv
sv/quoted_token_splitter.sv
sv/qts_checker.sv
tb/tb.sv
